>>> rtl/wmtl_pkg.sv
// ----------------------------------------------------------------------------
// wmtl_pkg
// Shared widths, codes and constants of the window median tank level filter.
// ----------------------------------------------------------------------------
package wmtl_pkg;

    localparam int DIST_W    = 13;
    localparam int LEVEL_W   = 7;
    localparam int TREND_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW = 2'd1;

    localparam logic [DIST_W-1:0] BOTTOM_RESET   = 13'd2100;
    localparam logic [DIST_W-1:0] OVERFLOW_RESET = 13'd50;

    // Fill level arithmetic in hundredths of a percent.
    localparam int HUND_W    = 14;
    localparam int PROD_W    = DIST_W + HUND_W;
    localparam logic [HUND_W-1:0] HUND_FULL   = 14'd10000;
    localparam logic [HUND_W-1:0] HUND_HALF   = 14'd50;
    localparam logic [HUND_W-1:0] HUND_PER_PCT = 14'd100;

    // floor(h / 100) == (h * 5243) >> 19 for every h up to 10000.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int SCALE_W = HUND_W + RECIP_W;

    typedef enum logic [TREND_W-1:0] {
        TREND_UNKNOWN = 2'd0,
        TREND_FALLING = 2'd1,
        TREND_RISING  = 2'd2
    } trend_t;

endpackage

>>> rtl/window_median_tank_level_top.sv
// A sample beat runs from acceptance back to ready through one multiply,
// 27 divider steps, one scale, one round. A zero or clamped level skips the divider.
// A report beat runs seven rounds of a binary search over the level value
// to its result, each one a pass of WINDOW ring reads.
// One beat is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset clears the ring valid bits, slot, trend and m_valid.
// ----------------------------------------------------------------------------
// window_median_tank_level_top
// Turns distance samples into fill percentages kept in a ring, and answers
// report ticks with the ring median and a falling/rising trend code.
// ----------------------------------------------------------------------------
module window_median_tank_level_top #(
    parameter int WINDOW = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wmtl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wmtl_pkg::DIST_W-1:0]   cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [wmtl_pkg::DIST_W-1:0]   s_distance_mm,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wmtl_pkg::LEVEL_W-1:0]  m_level_pct,
    output logic [wmtl_pkg::TREND_W-1:0]  m_trend
);

    localparam int ADDR_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int MED_COUNT = WINDOW / 2 + 1;
    localparam int DIV_STEPS = wmtl_pkg::PROD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int BIT_W     = $clog2(wmtl_pkg::LEVEL_W);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL    = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_SCALE  = 8'b0000_1000,
        ST_ROUND  = 8'b0001_0000,
        ST_COUNT  = 8'b0010_0000,
        ST_TALLY  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [wmtl_pkg::DIST_W-1:0]  bottom_reg, overflow_reg;
    logic [wmtl_pkg::DIST_W-1:0]  span_reg, span_next;
    logic [wmtl_pkg::DIST_W-1:0]  height_reg, height_next;
    logic                         zero_reg, zero_next;
    logic [wmtl_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [wmtl_pkg::DIST_W-1:0]  rem_reg, rem_next;
    logic [wmtl_pkg::HUND_W-1:0]  quot_reg, quot_next;
    logic [DCNT_W-1:0]            dcnt_reg, dcnt_next;
    logic [wmtl_pkg::HUND_W-1:0]  hund_reg, hund_next;
    logic [wmtl_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [ADDR_W-1:0]            slot_reg, slot_next;

    logic [ADDR_W-1:0]            addr_reg, addr_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [BIT_W-1:0]             bit_reg, bit_next;
    logic [wmtl_pkg::LEVEL_W-1:0] ans_reg, ans_next;

    logic [wmtl_pkg::LEVEL_W-1:0] last_level_reg, last_level_next;
    wmtl_pkg::trend_t             trend_reg, trend_next;
    logic                         m_valid_reg, m_valid_next;
    logic [wmtl_pkg::LEVEL_W-1:0] m_level_reg, m_level_next;

    // Divider step.
    logic [wmtl_pkg::DIST_W:0]    div_trial;
    logic                         div_ge;
    logic [wmtl_pkg::DIST_W:0]    div_diff;

    // Rounding.
    logic [7:0]                   whole;
    logic [wmtl_pkg::HUND_W-1:0]  whole_x100;
    logic [wmtl_pkg::HUND_W-1:0]  pct_rem;
    logic [wmtl_pkg::LEVEL_W-1:0] level_rounded;

    // Median search.
    logic [wmtl_pkg::LEVEL_W-1:0] rd_data;
    logic [wmtl_pkg::LEVEL_W-1:0] low_ones;
    logic [wmtl_pkg::LEVEL_W-1:0] trial;
    logic                         hit;
    logic [CNT_W-1:0]             cnt_sum;

    logic                         wr_en;
    logic                         rd_en;

    wmtl_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (level_rounded),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_level_pct = m_level_reg;
    assign m_trend     = trend_reg;

    assign div_trial = {rem_reg, prod_reg[wmtl_pkg::PROD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, span_reg});
    assign div_diff  = div_trial - {1'b0, span_reg};

    assign whole         = scale_reg[wmtl_pkg::SCALE_W-1:wmtl_pkg::RECIP_SHIFT];
    assign whole_x100    = wmtl_pkg::HUND_W'(whole) * wmtl_pkg::HUND_PER_PCT;
    assign pct_rem       = hund_reg - whole_x100;
    assign level_rounded = wmtl_pkg::LEVEL_W'(whole)
                         + wmtl_pkg::LEVEL_W'(pct_rem > wmtl_pkg::HUND_HALF);

    // Trial value of the search: bits already decided, current bit zero,
    // all lower bits one.
    assign low_ones = (wmtl_pkg::LEVEL_W'(1) << bit_reg) - wmtl_pkg::LEVEL_W'(1);
    assign trial    = ans_reg | low_ones;
    assign hit      = rd_vld_reg && (rd_data <= trial);
    assign cnt_sum  = cnt_reg + CNT_W'(hit);

    assign wr_en = (state_reg == ST_ROUND);
    assign rd_en = (state_reg == ST_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bottom_reg   <= wmtl_pkg::BOTTOM_RESET;
            overflow_reg <= wmtl_pkg::OVERFLOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wmtl_pkg::CFG_BOTTOM:   bottom_reg   <= cfg_data;
                wmtl_pkg::CFG_OVERFLOW: overflow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        span_next       = span_reg;
        height_next     = height_reg;
        zero_next       = zero_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        dcnt_next       = dcnt_reg;
        hund_next       = hund_reg;
        scale_next      = scale_reg;
        slot_next       = slot_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        cnt_next        = cnt_reg;
        bit_next        = bit_reg;
        ans_next        = ans_reg;
        last_level_next = last_level_reg;
        trend_next      = trend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_level_next    = m_level_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_kind) begin
                        span_next   = bottom_reg - overflow_reg;
                        height_next = bottom_reg - s_distance_mm;
                        zero_next   = (overflow_reg >= bottom_reg)
                                   || (s_distance_mm >= bottom_reg);
                        state_next  = ST_MUL;
                    end else begin
                        addr_next  = '0;
                        cnt_next   = '0;
                        bit_next   = BIT_W'(wmtl_pkg::LEVEL_W - 1);
                        ans_next   = '0;
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_MUL: begin
                prod_next = wmtl_pkg::PROD_W'(height_reg)
                          * wmtl_pkg::PROD_W'(wmtl_pkg::HUND_FULL);
                rem_next  = '0;
                quot_next = '0;
                dcnt_next = DCNT_W'(DIV_STEPS - 1);
                if (zero_reg) begin
                    hund_next  = '0;
                    state_next = ST_SCALE;
                end else if (height_reg > span_reg) begin
                    // Water above the overflow surface: the level clamps to full.
                    hund_next  = wmtl_pkg::HUND_FULL;
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? div_diff[wmtl_pkg::DIST_W-1:0]
                                   : div_trial[wmtl_pkg::DIST_W-1:0];
                quot_next = {quot_reg[wmtl_pkg::HUND_W-2:0], div_ge};
                prod_next = {prod_reg[wmtl_pkg::PROD_W-2:0], 1'b0};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0) begin
                    hund_next  = quot_next;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scale_next = wmtl_pkg::SCALE_W'(hund_reg)
                           * wmtl_pkg::SCALE_W'(wmtl_pkg::RECIP_100);
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (slot_reg == ADDR_W'(WINDOW - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + ADDR_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_COUNT: begin
                rd_vld_next = 1'b1;
                cnt_next    = cnt_sum;
                addr_next   = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(WINDOW - 1)) begin
                    state_next = ST_TALLY;
                end
            end
            ST_TALLY: begin
                // Too few entries at or below the trial: the median has this bit set.
                if (cnt_sum < CNT_W'(MED_COUNT)) begin
                    ans_next = ans_reg | (wmtl_pkg::LEVEL_W'(1) << bit_reg);
                end
                cnt_next  = '0;
                addr_next = '0;
                if (bit_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_COUNT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_level_next = ans_reg;
                    if (ans_reg < last_level_reg) begin
                        trend_next = wmtl_pkg::TREND_FALLING;
                    end else if (ans_reg > last_level_reg) begin
                        trend_next = wmtl_pkg::TREND_RISING;
                    end
                    last_level_next = ans_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            last_level_reg <= '0;
            trend_reg      <= wmtl_pkg::TREND_UNKNOWN;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            rd_vld_reg     <= rd_vld_next;
            last_level_reg <= last_level_next;
            trend_reg      <= trend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg    <= span_next;
        height_reg  <= height_next;
        zero_reg    <= zero_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        dcnt_reg    <= dcnt_next;
        hund_reg    <= hund_next;
        scale_reg   <= scale_next;
        addr_reg    <= addr_next;
        cnt_reg     <= cnt_next;
        bit_reg     <= bit_next;
        ans_reg     <= ans_next;
        m_level_reg <= m_level_next;
    end

endmodule

>>> rtl/wmtl_ring.sv
// ----------------------------------------------------------------------------
// wmtl_ring
// Level ring storage: one write and one registered read port, with a valid
// bit per entry so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module wmtl_ring #(
    parameter int DEPTH  = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [wmtl_pkg::LEVEL_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [wmtl_pkg::LEVEL_W-1:0] rd_data
);

    logic [wmtl_pkg::LEVEL_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]             valid_reg;
    logic [wmtl_pkg::LEVEL_W-1:0] rd_q_reg;
    logic                         rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg   <= mem_reg[rd_addr];
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule
